// ===== sv/gpr_pkg.sv =====
// Shared types and constants for the gray pyramid reduce block.
package gpr_pkg;

  localparam int MAX_WIDTH_DEF = 4096;
  localparam int RQ_DEPTH      = 4;

  localparam int PIX_W      = 8;
  localparam int COL_W      = 11;
  localparam int ROW_W      = 15;
  localparam int TDATA_W    = 40;
  localparam int PAD_W      = TDATA_W - PIX_W - COL_W - ROW_W;
  localparam int IW_W       = 13;
  localparam int IH_W       = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int LINE_W     = 24;
  localparam int VSUM_W     = 11;
  localparam int HSUM_W     = 14;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [IW_W-1:0] IMAGE_WIDTH_RST  = 13'd640;
  localparam logic [IH_W-1:0] IMAGE_HEIGHT_RST = 16'd480;

  localparam logic [1:0] KERNEL_W [4] = '{2'd1, 2'd3, 2'd3, 2'd1};
  localparam logic [HSUM_W-1:0] ROUND_BIAS = 14'd32;

  // tap source: current value, one, two or three steps back, or zero
  typedef enum logic [2:0] {
    TAP_CUR,
    TAP_D1,
    TAP_D2,
    TAP_D3,
    TAP_ZERO
  } tap_sel_e;

  typedef struct packed {
    logic [PIX_W-1:0]    pixel;
    tap_sel_e [1:0][3:0] vsel;
    tap_sel_e [1:0][3:0] hsel;
    logic [1:0]          nx;
    logic [1:0]          ny;
    logic [COL_W-1:0]    xs;
    logic [ROW_W-1:0]    ys;
    logic [1:0]          x_last;
    logic [1:0]          y_last;
  } item_t;

  typedef struct packed {
    logic [2:0]                 count;
    logic [3:0][PIX_W-1:0]      pixel;
    logic [3:0][COL_W-1:0]      col;
    logic [3:0][ROW_W-1:0]      row;
    logic [3:0]                 eof;
  } burst_t;

endpackage

// ===== sv/gpr_line_ram.sv =====
// Line store: single-port-write, single-port-read RAM with registered read data.
module gpr_line_ram #(
  parameter int Depth = gpr_pkg::MAX_WIDTH_DEF,
  parameter int AddrW = $clog2(Depth),
  parameter int DataW = gpr_pkg::LINE_W
) (
  input  logic             clk_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [DataW-1:0] rd_data_o,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [DataW-1:0] wr_data_i
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ===== sv/gpr_filter.sv =====
// Vertical and horizontal 1-3-3-1 filter stages with line store update.
module gpr_filter #(
  parameter int AddrW = $clog2(gpr_pkg::MAX_WIDTH_DEF)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  gpr_pkg::item_t            in_item_i,
  input  logic [AddrW-1:0]          in_addr_i,
  input  logic [gpr_pkg::LINE_W-1:0] rd_data_i,
  output logic                      wr_en_o,
  output logic [AddrW-1:0]          wr_addr_o,
  output logic [gpr_pkg::LINE_W-1:0] wr_data_o,
  output logic [1:0]                busy_o,
  output logic                      out_valid_o,
  output gpr_pkg::burst_t           out_burst_o
);
  import gpr_pkg::*;

  logic               s1_valid_q;
  item_t              s1_item_q;
  logic [AddrW-1:0]   s1_addr_q;
  logic               fwd_q;
  logic [LINE_W-1:0]  fwd_data_q;

  logic               s2_valid_q;
  item_t              s2_item_q;
  logic [VSUM_W-1:0]  cur_q [2];
  logic [VSUM_W-1:0]  snap_q [2][3];

  logic [VSUM_W-1:0]  cs_q [2][3];

  logic [LINE_W-1:0]  word;
  logic [VSUM_W-1:0]  cur [2];
  logic               fwd_d;

  // stage 1: vertical sums from line store word and new pixel
  always_comb begin
    logic [PIX_W-1:0] v;
    word = fwd_q ? fwd_data_q : rd_data_i;
    for (int s = 0; s < 2; s++) begin
      cur[s] = '0;
      for (int i = 0; i < 4; i++) begin
        case (s1_item_q.vsel[s][i])
          TAP_CUR: v = s1_item_q.pixel;
          TAP_D1:  v = word[7:0];
          TAP_D2:  v = word[15:8];
          TAP_D3:  v = word[23:16];
          default: v = '0;
        endcase
        cur[s] = cur[s] + VSUM_W'(v) * VSUM_W'(KERNEL_W[i]);
      end
    end
  end

  assign wr_en_o   = s1_valid_q;
  assign wr_addr_o = s1_addr_q;
  assign wr_data_o = {word[15:0], s1_item_q.pixel};
  assign fwd_d     = wr_en_o && (wr_addr_o == in_addr_i);
  assign busy_o    = {1'b0, s1_valid_q} + {1'b0, s2_valid_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      for (int s = 0; s < 2; s++) begin
        for (int k = 0; k < 3; k++) begin
          cs_q[s][k] <= '0;
        end
      end
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        for (int s = 0; s < 2; s++) begin
          if (s1_item_q.ny > 2'(s)) begin
            cs_q[s][2] <= cs_q[s][1];
            cs_q[s][1] <= cs_q[s][0];
            cs_q[s][0] <= cur[s];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) begin
      s1_item_q  <= in_item_i;
      s1_addr_q  <= in_addr_i;
      fwd_q      <= fwd_d;
      fwd_data_q <= wr_data_o;
    end
    if (s1_valid_q) begin
      s2_item_q <= s1_item_q;
      cur_q     <= cur;
      snap_q    <= cs_q;
    end
  end

  // stage 2: horizontal sums, rounding and burst assembly
  logic [PIX_W-1:0] hpix [2][2];

  always_comb begin
    logic [VSUM_W-1:0] v;
    logic [HSUM_W-1:0] acc;
    for (int s = 0; s < 2; s++) begin
      for (int t = 0; t < 2; t++) begin
        acc = ROUND_BIAS;
        for (int i = 0; i < 4; i++) begin
          case (s2_item_q.hsel[t][i])
            TAP_CUR: v = cur_q[s];
            TAP_D1:  v = snap_q[s][0];
            TAP_D2:  v = snap_q[s][1];
            TAP_D3:  v = snap_q[s][2];
            default: v = '0;
          endcase
          acc = acc + HSUM_W'(v) * HSUM_W'(KERNEL_W[i]);
        end
        hpix[s][t] = acc[HSUM_W-1:6];
      end
    end
  end

  always_comb begin
    int s;
    int t;
    out_burst_o = '0;
    case ({s2_item_q.ny, s2_item_q.nx})
      4'b0101: out_burst_o.count = 3'd1;
      4'b0110: out_burst_o.count = 3'd2;
      4'b1001: out_burst_o.count = 3'd2;
      4'b1010: out_burst_o.count = 3'd4;
      default: out_burst_o.count = 3'd0;
    endcase
    for (int k = 0; k < 4; k++) begin
      if (s2_item_q.nx == 2'd2) begin
        s = k / 2;
        t = k % 2;
      end else begin
        s = k % 2;
        t = 0;
      end
      out_burst_o.pixel[k] = hpix[s][t];
      out_burst_o.col[k]   = s2_item_q.xs + COL_W'(t);
      out_burst_o.row[k]   = s2_item_q.ys + ROW_W'(s);
      out_burst_o.eof[k]   = s2_item_q.x_last[t] & s2_item_q.y_last[s];
    end
  end

  assign out_valid_o = s2_valid_q && (out_burst_o.count != 3'd0);

endmodule

// ===== sv/gpr_out.sv =====
// Result queue of bursts and beat serialiser for the output stream.
module gpr_out #(
  parameter int Depth = gpr_pkg::RQ_DEPTH,
  parameter int CntW  = $clog2(Depth + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  gpr_pkg::burst_t             burst_i,
  output logic [CntW-1:0]             count_o,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [gpr_pkg::TDATA_W-1:0] m_axis_tdata,
  output logic                        m_axis_tlast,
  output logic                        m_axis_tuser
);
  import gpr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  burst_t          buf_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic [1:0]      beat_q;
  burst_t          head;
  logic            last_beat, fire, pop;

  assign head          = buf_q[rd_ptr_q];
  assign m_axis_tvalid = count_q != '0;
  assign last_beat     = {1'b0, beat_q} == head.count - 3'd1;
  assign fire          = m_axis_tvalid && m_axis_tready;
  assign pop           = fire && last_beat;
  assign count_o       = count_q;

  // tdata: out_pixel [7:0], out_col [18:8], out_row [33:19], zero above
  assign m_axis_tdata = {PAD_W'(0), head.row[beat_q], head.col[beat_q], head.pixel[beat_q]};
  assign m_axis_tlast = head.eof[beat_q];
  assign m_axis_tuser = last_beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      beat_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
        beat_q   <= '0;
      end else if (fire) begin
        beat_q <= beat_q + 2'd1;
      end
      count_q <= count_q + CntW'(push_i) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= burst_i;
    end
  end

endmodule

// ===== sv/gray_pyramid_reduce_4x4.sv =====
// Gray pyramid reduce top level: 4x4 binomial half-size image from a pixel stream.
//
// Source gray pixels enter on the s_axis channel in raster order, one per beat.
// Reduced pixels leave on the m_axis channel with their column and row; tlast
// marks the last reduced pixel of the frame, tuser the last result of a burst.
// Image size is set on the cfg channel (index 0 width, index 1 height); write it
// only while the block is idle, which it does not enforce; cfg_ready_o is always high.
// Throughput: one source pixel per clock while s_axis_tready is high, set by the
// one read and one write of the line store per cycle. An input pixel yields zero,
// one, two or four results; the four-result burst at the final corner takes four
// output beats. Results pass the stage 1 and stage 2 registers to the queue.
// Stall: results wait in a four-burst queue; s_axis_tready drops once queued
// plus in-flight bursts fill it, so nothing is lost while the receiver stalls.
// Reset: position counters clear, size returns to 640 x 480; the line store is
// not cleared, its entries are always written before they are used.
module gray_pyramid_reduce_4x4 #(
  parameter int MaxWidth = gpr_pkg::MAX_WIDTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [gpr_pkg::PIX_W-1:0]      s_axis_tdata,   // pixel [7:0]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [gpr_pkg::TDATA_W-1:0]    m_axis_tdata,   // out_pixel, out_col, out_row
  output logic                           m_axis_tlast,   // end_of_frame
  output logic                           m_axis_tuser,   // last_in_burst
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gpr_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [gpr_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import gpr_pkg::*;

  localparam int CW   = $clog2(MaxWidth);
  localparam int XW   = (CW + 1 > IW_W) ? CW + 1 : IW_W;
  localparam int CntW = $clog2(RQ_DEPTH + 1);

  function automatic logic signed [17:0] clamp_s(input logic signed [17:0] v,
                                                 input logic signed [17:0] hi);
    logic signed [17:0] res;
    res = v;
    if (v < 0) begin
      res = '0;
    end else if (v > hi) begin
      res = hi;
    end
    return res;
  endfunction

  function automatic tap_sel_e tap_code(input logic signed [17:0] d);
    tap_sel_e res;
    if (d <= 0) begin
      res = TAP_CUR;
    end else if (d == 18'sd1) begin
      res = TAP_D1;
    end else if (d == 18'sd2) begin
      res = TAP_D2;
    end else if (d == 18'sd3) begin
      res = TAP_D3;
    end else begin
      res = TAP_ZERO;
    end
    return res;
  endfunction

  logic [IW_W-1:0] iw_q;
  logic [IH_W-1:0] ih_q;
  logic [CW-1:0]   col_q, col_d;
  logic [IH_W-1:0] row_q, row_d;

  logic            accept;
  item_t           item;
  logic [CW-1:0]   c;
  logic [1:0]      busy;
  logic [CntW-1:0] q_count;

  logic                  rd_en;
  logic [LINE_W-1:0]     rd_data;
  logic                  wr_en;
  logic [CW-1:0]         wr_addr;
  logic [LINE_W-1:0]     wr_data;
  logic                  burst_valid;
  burst_t                burst;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ({1'b0, q_count} + (CntW + 1)'(busy)) < (CntW + 1)'(RQ_DEPTH);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rd_en         = accept;

  always_comb begin
    logic [XW-1:0]        iw_x, w_eff, wm1, c_x, col_x, lastx, xs;
    logic [IH_W-1:0]      h_eff, hm1, r, lasty, ys;
    logic                 col_last, row_last;
    logic [XW-1:0]        xt;
    logic [IH_W-1:0]      yt;
    logic signed [17:0]   raw, j;

    iw_x  = XW'(iw_q);
    w_eff = iw_x;
    if (iw_x == '0) begin
      w_eff = XW'(1);
    end else if (iw_x > XW'(MaxWidth)) begin
      w_eff = XW'(MaxWidth);
    end
    h_eff = (ih_q == '0) ? 16'd1 : ih_q;
    wm1   = w_eff - XW'(1);
    hm1   = h_eff - 16'd1;

    col_x    = XW'(col_q);
    c        = (col_x > wm1) ? wm1[CW-1:0] : col_q;
    c_x      = XW'(c);
    r        = (row_q > hm1) ? hm1 : row_q;
    col_last = c_x == wm1;
    row_last = r == hm1;
    lastx    = wm1 >> 1;
    lasty    = hm1 >> 1;

    item       = '0;
    item.pixel = s_axis_tdata;

    if (col_last) begin
      xs      = (c_x >= XW'(2)) ? (c_x - XW'(1)) >> 1 : '0;
      item.nx = 2'(lastx - xs + XW'(1));
    end else if (c_x >= XW'(2) && !c_x[0]) begin
      xs      = (c_x - XW'(2)) >> 1;
      item.nx = 2'd1;
    end else begin
      xs      = '0;
      item.nx = 2'd0;
    end

    if (row_last) begin
      ys      = (r >= 16'd2) ? (r - 16'd1) >> 1 : '0;
      item.ny = 2'(lasty - ys + 16'd1);
    end else if (r >= 16'd2 && !r[0]) begin
      ys      = (r - 16'd2) >> 1;
      item.ny = 2'd1;
    end else begin
      ys      = '0;
      item.ny = 2'd0;
    end

    item.xs = COL_W'(xs);
    item.ys = ROW_W'(ys);

    for (int t = 0; t < 2; t++) begin
      xt             = xs + XW'(t);
      item.x_last[t] = xt == lastx;
      for (int i = 0; i < 4; i++) begin
        raw = ($signed(18'(xt)) <<< 1) - 18'sd1 + $signed(18'(i));
        j   = clamp_s(raw, $signed(18'(wm1)));
        item.hsel[t][i] = tap_code($signed(18'(c_x)) - j);
      end
    end

    for (int s = 0; s < 2; s++) begin
      yt             = ys + IH_W'(s);
      item.y_last[s] = yt == lasty;
      for (int i = 0; i < 4; i++) begin
        raw = ($signed(18'(yt)) <<< 1) - 18'sd1 + $signed(18'(i));
        j   = clamp_s(raw, $signed(18'(hm1)));
        item.vsel[s][i] = tap_code($signed(18'(r)) - j);
      end
    end

    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : r + 16'd1;
      end else begin
        col_d = c + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q  <= IMAGE_WIDTH_RST;
      ih_q  <= IMAGE_HEIGHT_RST;
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_IMAGE_WIDTH:  iw_q <= cfg_wdata_i[IW_W-1:0];
          REG_IMAGE_HEIGHT: ih_q <= cfg_wdata_i[IH_W-1:0];
          default: ;
        endcase
      end
    end
  end

  gpr_line_ram #(
    .Depth (MaxWidth),
    .AddrW (CW),
    .DataW (LINE_W)
  ) u_line_ram (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (c),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  gpr_filter #(
    .AddrW (CW)
  ) u_filter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (accept),
    .in_item_i   (item),
    .in_addr_i   (c),
    .rd_data_i   (rd_data),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .busy_o      (busy),
    .out_valid_o (burst_valid),
    .out_burst_o (burst)
  );

  gpr_out #(
    .Depth (RQ_DEPTH),
    .CntW  (CntW)
  ) u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (burst_valid),
    .burst_i       (burst),
    .count_o       (q_count),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule
